[rtl/core/string_replace_all_macros.svh]
// Assertion helpers shared by the RTL of the find-and-replace block.
// Both sample on the rising edge of i_clk and stay quiet while reset is held.
`ifndef STRING_REPLACE_ALL_MACROS_SVH
`define STRING_REPLACE_ALL_MACROS_SVH

// A condition that must hold at every clock edge.
`define SRP_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// When pre holds at one edge, post must hold at the next edge.
`define SRP_CHECK_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/core/srp_pkg.sv]
package srp_pkg;

    localparam int NEEDLE_MAX      = 16;
    localparam int REPLACEMENT_MAX = 16;

    // Bytes that the two 64-bit pattern registers can hold.
    localparam int REG_BYTES  = 16;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int REPL_SLOTS = (REPLACEMENT_MAX > 0) ? REPLACEMENT_MAX : 1;
    localparam int CNT_W      = $clog2(NEEDLE_MAX + 1);
    localparam int RCNT_W     = $clog2(REPL_SLOTS + 1);
    localparam int WIN_IDX_W  = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int RIDX_W     = (REPL_SLOTS > 1) ? $clog2(REPL_SLOTS) : 1;
    localparam int OUT_CNT_W  = $clog2(NEEDLE_MAX + REPL_SLOTS + 1);

    // Queue between front and back, and the result queue; depths are powers of two.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_LO = 3'd0,
        REG_NEEDLE_HI = 3'd1,
        REG_NEEDLE_LEN = 3'd2,
        REG_REPL_LO = 3'd3,
        REG_REPL_HI = 3'd4,
        REG_REPL_LEN = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        HEAD_NONE,
        HEAD_BYTE,
        HEAD_REPL
    } t_head;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_empty;
        logic              out_last;
    } t_out_item;

    // Effective configuration as seen by the front and the back.
    typedef struct packed {
        logic [NEEDLE_MAX-1:0][BYTE_W-1:0] needle;
        logic [CNT_W-1:0]                  needle_len;
        logic [REPL_SLOTS-1:0][BYTE_W-1:0] repl;
        logic [RCNT_W-1:0]                 repl_len;
        logic                              win_clear;
    } t_cfg;

    // One command from the front: an optional head action, then an optional flush.
    typedef struct packed {
        t_head                             head;
        logic [BYTE_W-1:0]                 head_byte;
        logic [NEEDLE_MAX-1:0][BYTE_W-1:0] win;
        logic [CNT_W-1:0]                  flush_cnt;
        logic                              last;
    } t_cmd;

endpackage

[rtl/core/srp_cfg.sv]
module srp_cfg
    import srp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [CFG_DATA_W-1:0] r_needle_lo;
    logic [CFG_DATA_W-1:0] r_needle_hi;
    logic [LEN_W-1:0]      r_needle_len;
    logic [CFG_DATA_W-1:0] r_repl_lo;
    logic [CFG_DATA_W-1:0] r_repl_hi;
    logic [LEN_W-1:0]      r_repl_len;

    logic [2*CFG_DATA_W-1:0] needle_cat;
    logic [2*CFG_DATA_W-1:0] repl_cat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_lo  <= '0;
            r_needle_hi  <= '0;
            r_needle_len <= LEN_W'(1);
            r_repl_lo    <= '0;
            r_repl_hi    <= '0;
            r_repl_len   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NEEDLE_LO:  r_needle_lo  <= i_cfg_data;
                REG_NEEDLE_HI:  r_needle_hi  <= i_cfg_data;
                REG_NEEDLE_LEN: r_needle_len <= i_cfg_data[LEN_W-1:0];
                REG_REPL_LO:    r_repl_lo    <= i_cfg_data;
                REG_REPL_HI:    r_repl_hi    <= i_cfg_data;
                REG_REPL_LEN:   r_repl_len   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign needle_cat = {r_needle_hi, r_needle_lo};
    assign repl_cat   = {r_repl_hi, r_repl_lo};

    always_comb begin
        o_cfg = '0;
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            if (i < REG_BYTES) begin
                o_cfg.needle[i] = needle_cat[BYTE_W*i +: BYTE_W];
            end
        end
        for (int i = 0; i < REPL_SLOTS; i++) begin
            if (i < REG_BYTES) begin
                o_cfg.repl[i] = repl_cat[BYTE_W*i +: BYTE_W];
            end
        end

        // A zero needle length acts as one; both lengths saturate at the window sizes.
        if (r_needle_len == '0) begin
            o_cfg.needle_len = CNT_W'(1);
        end else if (int'(r_needle_len) > NEEDLE_MAX) begin
            o_cfg.needle_len = CNT_W'(NEEDLE_MAX);
        end else begin
            o_cfg.needle_len = CNT_W'(r_needle_len);
        end

        if (int'(r_repl_len) > REPLACEMENT_MAX) begin
            o_cfg.repl_len = RCNT_W'(REPLACEMENT_MAX);
        end else begin
            o_cfg.repl_len = RCNT_W'(r_repl_len);
        end

        // Writing the needle length drops whatever the window holds.
        o_cfg.win_clear = i_cfg_we && (i_cfg_idx == REG_NEEDLE_LEN);
    end

endmodule

[rtl/core/srp_front.sv]
`include "string_replace_all_macros.svh"

module srp_front
    import srp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_accept,
    input  t_in_item i_in,
    output logic     o_enq,
    output t_cmd     o_cmd
);

    logic [NEEDLE_MAX-1:0][BYTE_W-1:0] r_win;
    logic [CNT_W-1:0]                  r_cnt;

    logic [NEEDLE_MAX-1:0][BYTE_W-1:0] win_ins;
    logic [NEEDLE_MAX-1:0][BYTE_W-1:0] win_sh;
    logic [NEEDLE_MAX-1:0][BYTE_W-1:0] n_win;
    logic [CNT_W-1:0]                  cnt_inc;
    logic [CNT_W-1:0]                  cnt_after;
    logic [CNT_W-1:0]                  n_cnt;
    logic                              match;
    t_head                             head;

    always_comb begin
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            win_ins[i] = (r_cnt == CNT_W'(i)) ? i_in.in_byte : r_win[i];
        end
        for (int i = 0; i < NEEDLE_MAX - 1; i++) begin
            win_sh[i] = win_ins[i + 1];
        end
        win_sh[NEEDLE_MAX-1] = win_ins[NEEDLE_MAX-1];

        match = 1'b1;
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            if ((CNT_W'(i) < i_cfg.needle_len) && (win_ins[i] != i_cfg.needle[i])) begin
                match = 1'b0;
            end
        end

        cnt_inc = r_cnt + CNT_W'(1);
        if (cnt_inc != i_cfg.needle_len) begin
            head      = HEAD_NONE;
            n_win     = win_ins;
            cnt_after = cnt_inc;
        end else if (match) begin
            head      = HEAD_REPL;
            n_win     = win_ins;
            cnt_after = '0;
        end else begin
            // A full window that misses releases its oldest byte.
            head      = HEAD_BYTE;
            n_win     = win_sh;
            cnt_after = cnt_inc - CNT_W'(1);
        end

        n_cnt = i_in.in_last ? '0 : cnt_after;

        o_cmd.head      = head;
        o_cmd.head_byte = win_ins[0];
        o_cmd.win       = n_win;
        o_cmd.flush_cnt = i_in.in_last ? cnt_after : '0;
        o_cmd.last      = i_in.in_last;

        // A match with an empty replacement leaves nothing to do unless the text ends.
        o_enq = i_accept && ((head == HEAD_BYTE) || i_in.in_last ||
                             ((head == HEAD_REPL) && (i_cfg.repl_len != '0)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cfg.win_clear) begin
            r_cnt <= '0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

    `SRP_CHECK(a_window_below_needle, r_cnt < i_cfg.needle_len, "window holds a full needle")

endmodule

[rtl/core/srp_cmdq.sv]
`include "string_replace_all_macros.svh"

module srp_cmdq
    import srp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr;
    logic [CMDQ_PTR_W-1:0] r_rd;
    logic [CMDQ_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + CMDQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + CMDQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CMDQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CMDQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    `SRP_CHECK(a_cmdq_count_range, r_count <= CMDQ_CNT_W'(CMDQ_DEPTH), "queue count overflow")

endmodule

[rtl/core/srp_back.sv]
`include "string_replace_all_macros.svh"

module srp_back
    import srp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_out
);

    logic [OUT_CNT_W-1:0]  r_idx;
    t_out_item             r_oq [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_oq_wr;
    logic [OUTQ_PTR_W-1:0] r_oq_rd;
    logic [OUTQ_CNT_W-1:0] r_oq_cnt;

    logic [OUT_CNT_W-1:0] head_cnt;
    logic [OUT_CNT_W-1:0] total;
    logic [OUT_CNT_W-1:0] win_off;
    logic                 step;
    logic                 done;
    logic                 oq_pop;
    t_out_item            item;

    always_comb begin
        case (i_cmd.head)
            HEAD_BYTE: head_cnt = OUT_CNT_W'(1);
            HEAD_REPL: head_cnt = OUT_CNT_W'(i_cfg.repl_len);
            default:   head_cnt = '0;
        endcase
        total   = head_cnt + OUT_CNT_W'(i_cmd.flush_cnt);
        win_off = r_idx - head_cnt;

        step = i_cmd_valid && (r_oq_cnt != OUTQ_CNT_W'(OUTQ_DEPTH));
        done = (total == '0) || (r_idx == total - OUT_CNT_W'(1));

        // Head bytes first, then the flushed window; a command with nothing
        // to emit can only be the end of the text and yields a bare end mark.
        item = '0;
        if (total == '0) begin
            item.out_empty = 1'b1;
            item.out_last  = 1'b1;
        end else begin
            if (r_idx < head_cnt) begin
                item.out_byte = (i_cmd.head == HEAD_BYTE) ? i_cmd.head_byte
                                                          : i_cfg.repl[r_idx[RIDX_W-1:0]];
            end else begin
                item.out_byte = i_cmd.win[win_off[WIN_IDX_W-1:0]];
            end
            item.out_last = i_cmd.last && done;
        end

        o_cmd_pop = step && done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (step) begin
            r_idx <= done ? '0 : r_idx + OUT_CNT_W'(1);
        end
    end

    assign o_empty = (r_oq_cnt == '0);
    assign o_out   = r_oq[r_oq_rd];
    assign oq_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (step) begin
                r_oq_wr <= r_oq_wr + OUTQ_PTR_W'(1);
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + OUTQ_PTR_W'(1);
            end
            if (step && !oq_pop) begin
                r_oq_cnt <= r_oq_cnt + OUTQ_CNT_W'(1);
            end else if (oq_pop && !step) begin
                r_oq_cnt <= r_oq_cnt - OUTQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_oq[r_oq_wr] <= item;
        end
    end

    `SRP_CHECK(a_idx_idle, i_cmd_valid || (r_idx == '0), "item index moved without a command")
    `SRP_CHECK(a_end_mark_shape, o_empty || !o_out.out_empty || (o_out.out_last && (o_out.out_byte == '0)), "bare end mark malformed")
    `SRP_CHECK_NEXT(a_idx_advance, step && !done, r_idx == $past(r_idx) + OUT_CNT_W'(1), "item index skipped")

endmodule

[rtl/core/string_replace_all.sv]
// Streaming find-and-replace-all over a byte stream. Bytes enter one per cycle through
// push/full and leave through empty/pop. A window of up to needle_length - 1 bytes is held
// back; a full window equal to the needle is replaced by the replacement bytes (none when
// replacement_length is zero), otherwise its oldest byte goes out. Matches are leftmost and
// non-overlapping. The byte with in_last set flushes the window and its final result item
// carries out_last; if it leaves nothing to send, one item with out_empty set and out_byte
// zero is sent. Input is taken at one byte per cycle while the four-entry command queue has
// room. The back end emits one result item per cycle while the output queue has room;
// sustained input stays at one byte per cycle as long as replacements are no longer than
// the needle and results are popped. A result passes through the command queue and then
// the output queue, both registered, before it reaches the output. The user must write
// configuration only while the block is idle; the block itself does not enforce this.
// Writing needle_length drops any held bytes.
module string_replace_all
    import srp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_in,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_out
);

    t_cfg cfg;
    t_cmd front_cmd;
    t_cmd q_cmd;
    logic front_enq;
    logic q_valid;
    logic q_pop;
    logic accept;

    assign accept = push && !full;

    srp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    srp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_in     (i_in),
        .o_enq    (front_enq),
        .o_cmd    (front_cmd)
    );

    srp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_enq),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    srp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

[test/replace_all_checker.sv]
`timescale 1ns / 100ps

module replace_all_checker
    import srp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    input  logic                  full,
    input  t_in_item              i_in,
    input  logic                  empty,
    input  logic                  pop,
    input  t_out_item             o_out,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [CFG_DATA_W-1:0] needle_lo;
    logic [CFG_DATA_W-1:0] needle_hi;
    logic [LEN_W-1:0]      needle_len;
    logic [CFG_DATA_W-1:0] repl_lo;
    logic [CFG_DATA_W-1:0] repl_hi;
    logic [LEN_W-1:0]      repl_len;

    logic [BYTE_W-1:0] held_bytes [NEEDLE_MAX];
    int                held_count;
    t_out_item         rewritten_q[$];
    int                fails = 0;

    function automatic logic [BYTE_W-1:0] pattern_byte(input logic [CFG_DATA_W-1:0] lo,
                                                       input logic [CFG_DATA_W-1:0] hi,
                                                       input int idx);
        if (idx < 8) begin
            return lo[8*idx +: 8];
        end
        if (idx < REG_BYTES) begin
            return hi[8*(idx-8) +: 8];
        end
        return '0;
    endfunction

    function automatic t_out_item text_item(input logic [BYTE_W-1:0] b, input logic is_empty,
                                            input logic is_last);
        t_out_item it;
        it.out_byte  = b;
        it.out_empty = is_empty;
        it.out_last  = is_last;
        return it;
    endfunction

    // Runs one text byte through the window and queues the rewritten items it releases.
    task automatic rewrite_byte(input t_in_item item);
        int   window_len;
        int   repl_count;
        int   emitted;
        logic hit;
        window_len = (needle_len == 0) ? 1 :
                     (needle_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(needle_len);
        repl_count = (repl_len > REPLACEMENT_MAX) ? REPLACEMENT_MAX : int'(repl_len);
        emitted    = 0;
        held_bytes[held_count] = item.in_byte;
        held_count++;
        if (held_count == window_len) begin
            hit = 1'b1;
            for (int i = 0; i < window_len; i++) begin
                if (held_bytes[i] != pattern_byte(needle_lo, needle_hi, i)) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                for (int i = 0; i < repl_count; i++) begin
                    rewritten_q.push_back(text_item(pattern_byte(repl_lo, repl_hi, i),
                                                    1'b0, 1'b0));
                    emitted++;
                end
                held_count = 0;
            end else begin
                rewritten_q.push_back(text_item(held_bytes[0], 1'b0, 1'b0));
                emitted++;
                for (int i = 0; i < held_count - 1; i++) begin
                    held_bytes[i] = held_bytes[i+1];
                end
                held_count--;
            end
        end
        if (item.in_last) begin
            for (int i = 0; i < held_count; i++) begin
                rewritten_q.push_back(text_item(held_bytes[i], 1'b0, 1'b0));
                emitted++;
            end
            held_count = 0;
            // A text that rewrites to nothing still ends with a bare end mark.
            if (emitted == 0) begin
                rewritten_q.push_back(text_item('0, 1'b1, 1'b1));
            end else begin
                rewritten_q[rewritten_q.size()-1].out_last = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            needle_lo  = '0;
            needle_hi  = '0;
            needle_len = LEN_W'(1);
            repl_lo    = '0;
            repl_hi    = '0;
            repl_len   = '0;
            held_count = 0;
            rewritten_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_NEEDLE_LO: needle_lo = i_cfg_data;
                    REG_NEEDLE_HI: needle_hi = i_cfg_data;
                    REG_NEEDLE_LEN: begin
                        needle_len = i_cfg_data[LEN_W-1:0];
                        held_count = 0;
                    end
                    REG_REPL_LO:  repl_lo = i_cfg_data;
                    REG_REPL_HI:  repl_hi = i_cfg_data;
                    REG_REPL_LEN: repl_len = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                rewrite_byte(i_in);
            end
            if (pop && !empty) begin
                if (rewritten_q.size() == 0) begin
                    $error("unexpected item: out_byte %0h out_empty %0b out_last %0b",
                           o_out.out_byte, o_out.out_empty, o_out.out_last);
                    fails++;
                end else begin
                    want = rewritten_q.pop_front();
                    if (o_out.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, o_out.out_byte);
                        fails++;
                    end
                    if (o_out.out_empty !== want.out_empty) begin
                        $error("out_empty: expected %0b, got %0b",
                               want.out_empty, o_out.out_empty);
                        fails++;
                    end
                    if (o_out.out_last !== want.out_last) begin
                        $error("out_last: expected %0b, got %0b", want.out_last, o_out.out_last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= rewritten_q.size();
    end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
    import srp_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    t_in_item              i_in;
    logic                  empty;
    logic                  pop = 1'b0;
    t_out_item             o_out;

    int fail_count;
    int pending;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    // Stimulus-side copy of the needle, used to build texts that hit it.
    logic [BYTE_W-1:0] needle_tb [NEEDLE_MAX];
    int                needle_span = 1;

    always #1 i_clk = ~i_clk;

    string_replace_all DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out)
    );

    replace_all_checker u_replace_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_in         (i_in),
        .empty        (empty),
        .pop          (pop),
        .o_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        pop <= ($urandom_range(1, 100) > recv_stall_pct);
    end

    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic put_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] nlo, input logic [CFG_DATA_W-1:0] nhi,
                             input logic [LEN_W-1:0] nlen, input logic [CFG_DATA_W-1:0] rlo,
                             input logic [CFG_DATA_W-1:0] rhi, input logic [LEN_W-1:0] rlen);
        logic [CFG_DATA_W-1:0] junk;
        drain_results();
        // Held bytes produce no results, so give the block time to settle.
        repeat (32) @(posedge i_clk);
        junk = {$urandom, $urandom};
        put_reg(REG_NEEDLE_LO, nlo);
        put_reg(REG_NEEDLE_HI, nhi);
        put_reg(REG_NEEDLE_LEN, {junk[CFG_DATA_W-1:LEN_W], nlen});
        put_reg(REG_REPL_LO, rlo);
        put_reg(REG_REPL_HI, rhi);
        put_reg(REG_REPL_LEN, {junk[CFG_DATA_W-1:LEN_W], rlen});
        i_cfg_we <= 1'b0;
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            needle_tb[i] = (i < 8) ? nlo[8*i +: 8] : nhi[8*(i-8) +: 8];
        end
        needle_span = (nlen == 0) ? 1 : (nlen > NEEDLE_MAX) ? NEEDLE_MAX : int'(nlen);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while ($urandom_range(1, 100) <= send_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= '{in_byte: b, in_last: last};
        do @(posedge i_clk); while (full);
    endtask

    task automatic random_setup();
        logic [BYTE_W-1:0]     base;
        logic [CFG_DATA_W-1:0] nlo;
        logic [CFG_DATA_W-1:0] nhi;
        logic [LEN_W-1:0]      nlen;
        logic [LEN_W-1:0]      rlen;
        base = BYTE_W'($urandom);
        for (int i = 0; i < REG_BYTES; i++) begin
            // Mostly two neighboring values, so that needles overlap with themselves.
            if ($urandom_range(0, 3) == 0) begin
                base = BYTE_W'($urandom);
            end
            if (i < 8) begin
                nlo[8*i +: 8] = base + BYTE_W'($urandom_range(0, 1));
            end else begin
                nhi[8*(i-8) +: 8] = base + BYTE_W'($urandom_range(0, 1));
            end
        end
        case ($urandom_range(0, 9)) inside
            0:       nlen = '0;
            1:       nlen = LEN_W'(NEEDLE_MAX);
            2:       nlen = LEN_W'($urandom_range(17, 31));
            [3:5]:   nlen = LEN_W'($urandom_range(1, 3));
            default: nlen = LEN_W'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 7))
            0:       rlen = '0;
            1:       rlen = LEN_W'(REPLACEMENT_MAX);
            2:       rlen = LEN_W'($urandom_range(17, 31));
            default: rlen = LEN_W'($urandom_range(0, 6));
        endcase
        configure(nlo, nhi, nlen, {$urandom, $urandom}, {$urandom, $urandom}, rlen);
    endtask

    // Builds a text out of needle copies, needle prefixes and stray bytes, then sends it.
    task automatic send_text(input int len, input logic close, output int sent);
        logic [BYTE_W-1:0] text[$];
        int                cut;
        while (text.size() < len) begin
            case ($urandom_range(0, 5)) inside
                [0:1]: begin
                    for (int i = 0; i < needle_span; i++) text.push_back(needle_tb[i]);
                end
                2: begin
                    cut = $urandom_range(1, needle_span);
                    for (int i = 0; i < cut; i++) text.push_back(needle_tb[i]);
                end
                3:       text.push_back(BYTE_W'($urandom));
                default: text.push_back(needle_tb[$urandom_range(0, needle_span - 1)]);
            endcase
        end
        for (int k = 0; k < text.size(); k++) begin
            if (k == 1 && $urandom_range(0, 7) == 0) begin
                drain_results();
            end
            send_byte(text[k], close && (k == text.size() - 1));
        end
        sent = text.size();
    endtask

    initial begin
        int len;
        int count;
        int sent;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        push       <= 1'b0;
        i_in       <= '0;
        for (int i = 0; i < NEEDLE_MAX; i++) needle_tb[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings delete every zero byte; a text of one zero ends in a bare end mark.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        configure(64'h5A5A_5A5A_5A5A_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2,
                  64'h1234_5678_9A80_00FF, 64'h0, 5'd3);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Needle length zero acts as one; an oversized replacement length saturates.
        configure(64'h0000_0000_0000_00FF, 64'h0, 5'd0,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF, 5'd31);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);

        // An oversized needle length saturates to the full sixteen bytes.
        configure(64'hF00F_8001_7E81_FF00, 64'h00FF_55AA_0102_0408, 5'd31,
                  {$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
        for (int i = 0; i < NEEDLE_MAX; i++) begin
            send_byte(needle_tb[i], i == NEEDLE_MAX - 1);
        end

        for (int ph = 0; ph < 9; ph++) begin
            case (ph % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_gap_pct = 47; recv_stall_pct <= 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct <= 47; end
                default: begin send_gap_pct = 30; recv_stall_pct <= 30; end
            endcase
            random_setup();
            count = 0;
            while (count < 32) begin
                len = $urandom_range(1, 16);
                // The last text of a phase is sometimes left open, so the
                // needle length write that follows drops held bytes.
                send_text(len, !((count + len >= 32) && ($urandom_range(0, 2) == 0)), sent);
                count += sent;
            end
        end

        drain_results();
        repeat (32) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
